### sv/bba_pkg.sv
// Package for the buddy block allocator: sizes, register indexes and payload types.
// Used by the allocator top level, its port checker, the testbench checker and the testbench top.
`default_nettype none
package bba_pkg;
  localparam int MIN_BLOCK_LOG2 = 6;
  localparam int TREE_LEVELS = 10;
  localparam int MAX_LOG2 = MIN_BLOCK_LOG2 + TREE_LEVELS;
  localparam int NODE_COUNT = 2047;
  localparam int NODE_W = 11;
  localparam int CNT_W = 11;
  localparam int DEPTH_W = 4;
  localparam int LOG_W = 5;
  localparam int SIZE_W = 17;
  localparam int RAM_DEPTH = 2048;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_SIZE = 2'd1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE = 1'b1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BAD_SIZE = 2'd1;
  localparam logic [1:0] ST_NO_BLOCK = 2'd2;
  localparam logic [1:0] ST_NOT_ALLOC = 2'd3;

  typedef struct packed {
    logic        operation;
    logic [31:0] request_size;
    logic [31:0] block_address;
  } bba_in_t;

  typedef struct packed {
    logic [31:0]       result_address;
    logic [1:0]        status;
    logic [SIZE_W-1:0] used_bytes;
    logic [SIZE_W-1:0] free_bytes;
  } bba_out_t;
endpackage
`default_nettype wire

### sv/bba_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### sv/buddy_block_allocator_unit.sv
// Top level of the buddy block allocator: sequencer over the mark and count RAMs.
// Depends on bba_pkg and bba_ram.
//
// Channel   Direction  Handshake                    Payload
// request   in         start high, busy low         request (bba_in_t)
// result    out        result_valid, one cycle      result (bba_out_t)
// config    in         cfg_valid and cfg_ready      cfg_index, cfg_data
//
// After reset a clearing pass zeroes the 2047 node entries of both RAMs while busy is high.
// An allocate reads and then checks each node scanned at its level (up to 1024 nodes),
// writes each node of the marked subtree in turn, and reads then writes each node on
// the walk from the block up to the root. A free reads and checks each node on its
// descent, then does the same marking and walk. The done state follows the last RAM
// write and the result strobe is registered from it; the receiver cannot stall.
`default_nettype none
module buddy_block_allocator_unit
  import bba_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire bba_in_t              request,
  output logic                      result_valid,
  output bba_out_t                  result,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);
  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_SCAN_RD  = 4'd2;
  localparam logic [3:0] S_SCAN_CHK = 4'd3;
  localparam logic [3:0] S_FREE_RD  = 4'd4;
  localparam logic [3:0] S_FREE_CHK = 4'd5;
  localparam logic [3:0] S_MARK     = 4'd6;
  localparam logic [3:0] S_UP_RD    = 4'd7;
  localparam logic [3:0] S_UP_WR    = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  logic [3:0]         state;
  logic [NODE_W-1:0]  clear_addr;
  logic [NODE_W-1:0]  node;
  logic [DEPTH_W-1:0] depth;
  logic [NODE_W-1:0]  scan_first;
  logic [NODE_W-1:0]  scan_last;
  logic [NODE_W-1:0]  target;
  logic [DEPTH_W-1:0] tdepth;
  logic [DEPTH_W-1:0] mdepth;
  logic [NODE_W-1:0]  row_start;
  logic [NODE_W-1:0]  row_len;
  logic [NODE_W-1:0]  row_pos;
  logic               op;
  logic [1:0]         status;
  logic [31:0]        granted;
  logic [SIZE_W-1:0]  used_total;
  logic [31:0]        base_address;
  logic [SIZE_W-1:0]  total_size;

  logic               mark_we;
  logic [NODE_W-1:0]  mark_waddr;
  logic               mark_wdata;
  logic               mark_rdata;
  logic               cnt_we;
  logic [NODE_W-1:0]  cnt_waddr;
  logic [CNT_W-1:0]   cnt_wdata;
  logic [CNT_W-1:0]   cnt_rdata;

  logic [15:0]        size_m1;
  logic [LOG_W-1:0]   a_log;
  logic [LOG_W-1:0]   a_depth;
  logic [NODE_W-1:0]  a_first;
  logic [31:0]        rel;
  logic [LOG_W-1:0]   f_lvl;
  logic [LOG_W-1:0]   f_depth;
  logic [NODE_W-1:0]  f_node;
  logic [LOG_W-1:0]   t_log;
  logic [SIZE_W-1:0]  blk_size;

  always_comb begin
    size_m1 = request.request_size[15:0] - 16'd1;
    a_log = '0;
    for (int i = 0; i < 16; i++) begin
      if (size_m1[i]) begin
        a_log = LOG_W'(i + 1);
      end
    end
    if (a_log < LOG_W'(MIN_BLOCK_LOG2)) begin
      a_log = LOG_W'(MIN_BLOCK_LOG2);
    end
    a_depth = LOG_W'(MAX_LOG2) - a_log;
    a_first = (NODE_W'(1) << a_depth) - NODE_W'(1);

    rel = request.block_address - base_address;
    f_lvl = LOG_W'(MAX_LOG2);
    for (int i = 15; i >= 0; i--) begin
      if (rel[i]) begin
        f_lvl = LOG_W'(i);
      end
    end
    f_depth = LOG_W'(MAX_LOG2) - f_lvl;
    f_node = (NODE_W'(1) << f_depth) - NODE_W'(1) + NODE_W'(rel[15:0] >> f_lvl);

    t_log = LOG_W'(MAX_LOG2) - LOG_W'(tdepth);
    blk_size = SIZE_W'(1) << t_log;
  end

  always_comb begin
    mark_we = (state == S_CLEAR) || (state == S_MARK);
    mark_waddr = (state == S_CLEAR) ? clear_addr : row_start + row_pos;
    mark_wdata = (state == S_CLEAR) ? 1'b0 : (op == OP_ALLOC);
    cnt_we = (state == S_CLEAR) || (state == S_UP_WR);
    cnt_waddr = (state == S_CLEAR) ? clear_addr : node;
    if (state == S_CLEAR) begin
      cnt_wdata = '0;
    end else if (op == OP_ALLOC) begin
      cnt_wdata = cnt_rdata + CNT_W'(1);
    end else begin
      cnt_wdata = cnt_rdata - CNT_W'(1);
    end
  end

  bba_ram #(.WIDTH(1), .DEPTH(RAM_DEPTH)) u_mark_ram (
    .clk(clk), .we(mark_we), .waddr(mark_waddr), .wdata(mark_wdata),
    .raddr(node), .rdata(mark_rdata)
  );

  bba_ram #(.WIDTH(CNT_W), .DEPTH(RAM_DEPTH)) u_cnt_ram (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(node), .rdata(cnt_rdata)
  );

  assign busy = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clear_addr <= '0;
      used_total <= '0;
      base_address <= '0;
      total_size <= SIZE_W'(65536);
      result_valid <= 1'b0;
      node <= '0;
    end else begin
      result_valid <= (state == S_DONE);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_BASE_ADDRESS) begin
          base_address <= cfg_data;
        end else if (cfg_index == CFG_TOTAL_SIZE) begin
          total_size <= cfg_data[SIZE_W-1:0];
        end
      end
      unique case (state)
        S_CLEAR: begin
          clear_addr <= clear_addr + NODE_W'(1);
          if (clear_addr == NODE_W'(NODE_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            op <= request.operation;
            granted <= '0;
            if (request.operation == OP_ALLOC) begin
              if (request.request_size == 32'd0 || request.request_size > 32'd65536) begin
                status <= ST_BAD_SIZE;
                state <= S_DONE;
              end else begin
                status <= ST_OK;
                depth <= a_depth[DEPTH_W-1:0];
                node <= a_first;
                scan_first <= a_first;
                scan_last <= NODE_W'(a_first << 1);
                state <= S_SCAN_RD;
              end
            end else begin
              if (rel[31:16] != 16'd0 || f_lvl < LOG_W'(MIN_BLOCK_LOG2)) begin
                status <= ST_NOT_ALLOC;
                state <= S_DONE;
              end else begin
                status <= ST_OK;
                depth <= f_depth[DEPTH_W-1:0];
                node <= f_node;
                state <= S_FREE_RD;
              end
            end
          end
        end
        S_SCAN_RD: begin
          state <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          if (!mark_rdata && cnt_rdata == '0) begin
            target <= node;
            tdepth <= depth;
            mdepth <= depth;
            row_start <= node;
            row_len <= NODE_W'(1);
            row_pos <= '0;
            granted <= base_address
                       + (32'(node - scan_first) << (LOG_W'(MAX_LOG2) - LOG_W'(depth)));
            state <= S_MARK;
          end else if (node == scan_last) begin
            status <= ST_NO_BLOCK;
            state <= S_DONE;
          end else begin
            node <= node + NODE_W'(1);
            state <= S_SCAN_RD;
          end
        end
        S_FREE_RD: begin
          state <= S_FREE_CHK;
        end
        S_FREE_CHK: begin
          if (mark_rdata) begin
            if (cnt_rdata == '0) begin
              status <= ST_NOT_ALLOC;
              state <= S_DONE;
            end else begin
              target <= node;
              tdepth <= depth;
              mdepth <= depth;
              row_start <= node;
              row_len <= NODE_W'(1);
              row_pos <= '0;
              state <= S_MARK;
            end
          end else if (depth >= DEPTH_W'(TREE_LEVELS)) begin
            status <= ST_NOT_ALLOC;
            state <= S_DONE;
          end else begin
            node <= NODE_W'({node, 1'b1});
            depth <= depth + DEPTH_W'(1);
            state <= S_FREE_RD;
          end
        end
        S_MARK: begin
          if (row_pos == row_len - NODE_W'(1)) begin
            if (mdepth == DEPTH_W'(TREE_LEVELS)) begin
              node <= target;
              state <= S_UP_RD;
            end else begin
              row_start <= NODE_W'({row_start, 1'b1});
              row_len <= NODE_W'(row_len << 1);
              row_pos <= '0;
              mdepth <= mdepth + DEPTH_W'(1);
            end
          end else begin
            row_pos <= row_pos + NODE_W'(1);
          end
        end
        S_UP_RD: begin
          state <= S_UP_WR;
        end
        S_UP_WR: begin
          if (node == '0) begin
            if (op == OP_ALLOC) begin
              used_total <= used_total + blk_size;
            end else begin
              used_total <= (used_total >= blk_size) ? used_total - blk_size : '0;
            end
            state <= S_DONE;
          end else begin
            node <= (node - NODE_W'(1)) >> 1;
            state <= S_UP_RD;
          end
        end
        S_DONE: begin
          result.result_address <= (status == ST_OK && op == OP_ALLOC) ? granted : '0;
          result.status <= status;
          result.used_bytes <= used_total;
          result.free_bytes <= (total_size > used_total) ? total_size - used_total : '0;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

### sv/bba_checker.sv
// Port-level checker for the buddy block allocator, bound to the top level.
// Depends on bba_pkg and buddy_block_allocator_unit.
`default_nettype none
module bba_port_checker
  import bba_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     start,
  input wire logic     busy,
  input wire logic     result_valid,
  input wire bba_out_t result
);
  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe lasted more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (!busy && $past(busy)))
    else $error("result appeared without a transaction in progress");

  a_fail_zero_addr: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status != ST_OK) |-> (result.result_address == 32'd0))
    else $error("failed transaction returned a nonzero address");
endmodule

bind buddy_block_allocator_unit bba_port_checker u_bba_port_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy),
  .result_valid(result_valid), .result(result)
);
`default_nettype wire

### tb/sv/bba_checker.sv
// Checker for the buddy block allocator: predicts each result from the accepted
// requests and register writes, and compares. Depends on bba_pkg.
`timescale 1ns / 100ps
`default_nettype none
module bba_checker
  import bba_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic                 busy,
  input  wire bba_in_t              request,
  input  wire logic                 result_valid,
  input  wire bba_out_t             result,
  input  wire logic                 cfg_valid,
  input  wire logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data,
  output int                        errors,
  output int                        pending
);
  logic              mark [NODE_COUNT];
  logic [CNT_W-1:0]  cnt [NODE_COUNT];
  logic [31:0]       base_q;
  logic [SIZE_W-1:0] total_q;
  longint            used_q;
  bba_out_t          expected_q [$];

  assign pending = expected_q.size();

  function automatic void set_subtree(int node, int depth, logic v);
    int first;
    for (int k = 0; depth + k <= TREE_LEVELS; k++) begin
      first = ((node + 1) << k) - 1;
      for (int i = 0; i < (1 << k); i++) begin
        if (first + i < NODE_COUNT) mark[first + i] = v;
      end
    end
  endfunction

  function automatic void adjust_ancestors(int node, bit raise);
    int n;
    n = node;
    forever begin
      cnt[n] = raise ? cnt[n] + 1'b1 : cnt[n] - 1'b1;
      if (n == 0) break;
      n = (n - 1) >> 1;
    end
  endfunction

  function automatic logic [1:0] allocate_block(logic [31:0] size, output logic [31:0] addr);
    int e, depth, first, last, node;
    addr = '0;
    if (size == 0) return ST_BAD_SIZE;
    e = 0;
    while (e < 33 && (64'd1 << e) < {32'd0, size}) e++;
    if (e < MIN_BLOCK_LOG2) e = MIN_BLOCK_LOG2;
    if (e > MAX_LOG2) return ST_BAD_SIZE;
    depth = MAX_LOG2 - e;
    first = (1 << depth) - 1;
    last = (1 << (depth + 1)) - 1;
    for (node = first; node < last; node++) begin
      if (!mark[node] && cnt[node] == 0) break;
    end
    if (node >= last) return ST_NO_BLOCK;
    set_subtree(node, depth, 1'b1);
    adjust_ancestors(node, 1'b1);
    used_q += longint'(1) << e;
    addr = base_q + 32'((node - first) << e);
    return ST_OK;
  endfunction

  function automatic logic [1:0] free_block(logic [31:0] address);
    logic [31:0] rel;
    int lvl, depth, node;
    longint sz;
    rel = address - base_q;
    if ((rel >> MAX_LOG2) != 0) return ST_NOT_ALLOC;
    lvl = MAX_LOG2;
    if (rel != 0) begin
      lvl = 0;
      while (lvl < MAX_LOG2 && rel[lvl] == 1'b0) lvl++;
    end
    if (lvl < MIN_BLOCK_LOG2) return ST_NOT_ALLOC;
    depth = MAX_LOG2 - lvl;
    node = (1 << depth) - 1 + int'(rel >> lvl);
    forever begin
      if (node >= NODE_COUNT) return ST_NOT_ALLOC;
      if (mark[node]) begin
        if (cnt[node] == 0) return ST_NOT_ALLOC;
        break;
      end
      if (depth >= TREE_LEVELS) return ST_NOT_ALLOC;
      node = 2 * node + 1;
      depth++;
      lvl--;
    end
    set_subtree(node, depth, 1'b0);
    adjust_ancestors(node, 1'b0);
    sz = longint'(1) << lvl;
    used_q = used_q >= sz ? used_q - sz : 0;
    return ST_OK;
  endfunction

  always @(posedge clk) begin
    bba_out_t exp_r;
    logic [31:0] addr;
    if (rst) begin
      for (int i = 0; i < NODE_COUNT; i++) begin
        mark[i] = 1'b0;
        cnt[i] = '0;
      end
      base_q = '0;
      total_q = 17'd65536;
      used_q = 0;
      errors = 0;
      expected_q.delete();
    end else begin
      if (result_valid) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result transaction");
          errors++;
        end else begin
          exp_r = expected_q.pop_front();
          if (result.result_address !== exp_r.result_address) begin
            $error("result_address expected %h actual %h", exp_r.result_address,
                   result.result_address);
            errors++;
          end
          if (result.status !== exp_r.status) begin
            $error("status expected %0d actual %0d", exp_r.status, result.status);
            errors++;
          end
          if (result.used_bytes !== exp_r.used_bytes) begin
            $error("used_bytes expected %0d actual %0d", exp_r.used_bytes,
                   result.used_bytes);
            errors++;
          end
          if (result.free_bytes !== exp_r.free_bytes) begin
            $error("free_bytes expected %0d actual %0d", exp_r.free_bytes,
                   result.free_bytes);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_BASE_ADDRESS) base_q = cfg_data;
        else if (cfg_index == CFG_TOTAL_SIZE) total_q = cfg_data[SIZE_W-1:0];
      end
      if (start && !busy) begin
        if (request.operation == OP_ALLOC) begin
          exp_r.status = allocate_block(request.request_size, addr);
          exp_r.result_address = (exp_r.status == ST_OK) ? addr : '0;
        end else begin
          exp_r.status = free_block(request.block_address);
          exp_r.result_address = '0;
        end
        exp_r.used_bytes = used_q[SIZE_W-1:0];
        exp_r.free_bytes = (longint'(total_q) > used_q) ?
                           SIZE_W'(longint'(total_q) - used_q) : '0;
        expected_q.push_back(exp_r);
      end
    end
  end
endmodule
`default_nettype wire

### tb/sv/tb.sv
// Testbench top for the buddy block allocator: clock, reset, stimulus and verdict.
// Depends on bba_pkg, buddy_block_allocator_unit and bba_checker.
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import bba_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  bba_in_t request = '0;
  logic result_valid;
  bba_out_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int errors;
  int pending;
  int idle_cycles = 0;
  logic [31:0] base_now = '0;
  logic [31:0] live_blocks [$];
  bit quiet = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  buddy_block_allocator_unit DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  bba_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  always @(posedge clk) begin
    if ((start && !busy) || result_valid || (cfg_valid && cfg_ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (result_valid && result.status == ST_OK && result.result_address != 0)
      live_blocks.push_back(result.result_address);
  end

  task automatic send_op(logic op, logic [31:0] size, logic [31:0] addr);
    if (!quiet && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 6)) @(posedge clk);
    start <= 1'b1;
    request <= '{operation: op, request_size: size, block_address: addr};
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_BASE_ADDRESS) base_now = data;
    @(posedge clk);
  endtask

  task automatic random_ops(int count);
    int pick;
    logic [31:0] a;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 9);
      if (i > count * 4 / 5) quiet = 1'b1;
      if (pick < 5) begin
        case ($urandom_range(0, 5))
          0: a = $urandom_range(1, 64);
          1, 2: a = $urandom_range(1, 1024);
          3: a = $urandom_range(1, 8192);
          4: a = $urandom_range(0, 70000);
          default: a = $urandom;
        endcase
        send_op(OP_ALLOC, a, $urandom);
      end else if (pick < 9 && live_blocks.size() != 0) begin
        a = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
        if ($urandom_range(0, 7) == 0) a = a + 32'($urandom_range(1, 128));
        send_op(OP_FREE, $urandom, a);
      end else begin
        a = ($urandom_range(0, 1) == 1) ? $urandom : base_now + 32'($urandom_range(0, 1023) << 6);
        send_op(OP_FREE, $urandom, a);
      end
      if (live_blocks.size() > 64) void'(live_blocks.pop_front());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_op(OP_ALLOC, 32'd0, '0);
    send_op(OP_ALLOC, 32'd1, '0);
    send_op(OP_ALLOC, 32'd64, '0);
    send_op(OP_ALLOC, 32'd65, '0);
    send_op(OP_ALLOC, 32'd65537, '0);
    send_op(OP_ALLOC, 32'hFFFF_FFFF, '0);
    send_op(OP_FREE, 32'hFFFF_FFFF, 32'd64);
    send_op(OP_FREE, '0, 32'd32);
    send_op(OP_FREE, '0, 32'd128);
    send_op(OP_FREE, '0, 32'd65536);
    send_op(OP_FREE, '0, 32'hFFFF_FFC0);
    send_op(OP_FREE, '0, 32'd0);
    send_op(OP_ALLOC, 32'd65536, '0);
    send_op(OP_ALLOC, 32'd64, '0);
    send_op(OP_FREE, '0, 32'd0);
    send_op(OP_ALLOC, 32'd32768, '0);
    send_op(OP_ALLOC, 32'd32768, '0);
    send_op(OP_ALLOC, 32'd32768, '0);
    send_op(OP_FREE, '0, 32'd0);
    send_op(OP_FREE, '0, 32'd32768);
    drain_results();
    live_blocks.delete();
    write_reg(CFG_BASE_ADDRESS, 32'hFFFF_8000);
    write_reg(CFG_TOTAL_SIZE, 32'd0);
    send_op(OP_ALLOC, 32'd65536, '0);
    send_op(OP_FREE, '0, 32'hFFFF_8000);
    random_ops(130);
    drain_results();
    write_reg(CFG_BASE_ADDRESS, $urandom);
    write_reg(CFG_TOTAL_SIZE, 32'd65536);
    random_ops(130);
    drain_results();
    write_reg(CFG_BASE_ADDRESS, 32'h0);
    write_reg(CFG_TOTAL_SIZE, 32'h1_FFFF);
    random_ops(140);
    drain_results();
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
